[sv/etd_pkg.sv]
// Shared types, character constants and hex helpers for the escape text decoder.
package etd_pkg;

    localparam logic [7:0] ESC_CHAR = 8'h3D;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_A    = 8'h41;
    localparam logic [7:0] CHR_F    = 8'h46;
    localparam logic [7:0] HEX_A_OFS = CHR_A - 8'd10;
    localparam logic [3:0] MIN_HIGH_DIGIT = 4'd2;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } res_item_t;

    typedef struct packed {
        logic [1:0]                       n;
        res_item_t [MAX_RESULTS-1:0]      item;
    } res_t;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = ((b >= CHR_0) && (b <= CHR_9)) || ((b >= CHR_A) && (b <= CHR_F));
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] b);
        logic [7:0] v;
        if (b <= CHR_9)
        begin
            v = b - CHR_0;
        end
        else
        begin
            v = b - HEX_A_OFS;
        end
        hex_nib = v[3:0];
    endfunction

endpackage

[sv/escape_text_decoder.sv]
// Top level of the escape text decoder: stream ports, recognizer and result queue.
//
// Decodes '=' plus two upper-case hex digits (high digit 2 or more) into one byte;
// failed or unfinished escapes pass through literally. One input byte is taken per
// cycle while the result queue holds at most one entry; a byte yields zero to three
// results and the output port moves one result per cycle while m_tready is high, so
// plain text sustains one byte per cycle, while bytes that release several buffered
// results stall the input until the queue drains. A byte's results are written into
// the four-entry result queue as it is accepted; that queue sets the stall threshold.
module escape_text_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);
    import etd_pkg::*;

    res_t                   res;
    res_item_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      head_reg;
    logic [QPTR_W-1:0]      head_next;
    logic [QPTR_W-1:0]      tail_reg;
    logic [QPTR_W-1:0]      tail_next;
    logic [QCNT_W-1:0]      count_reg;
    logic [QCNT_W-1:0]      count_next;
    logic                   accept;
    logic                   pop;
    logic [1:0]             push_n;

    etd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (res)
    );

    assign s_tready = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign push_n   = accept ? res.n : 2'd0;
    assign m_tdata  = queue_mem[head_reg].data;
    assign m_tlast  = queue_mem[head_reg].last;

    assign head_next  = head_reg + QPTR_W'(pop);
    assign tail_next  = tail_reg + QPTR_W'(push_n);
    assign count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                queue_mem[tail_reg + QPTR_W'(i)] <= res.item[i];
            end
        end
    end

endmodule

[sv/etd_decode.sv]
// Escape recognizer: holds the open escape and forms up to three results per byte.
module etd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output etd_pkg::res_t    res
);
    import etd_pkg::*;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_ESC,
        PEND_HIGH
    } pend_state_t;

    pend_state_t state_reg;
    pend_state_t state_next;
    logic [7:0]  high_reg;
    logic [7:0]  high_next;
    logic        b_hex;
    logic [3:0]  b_nib;

    assign b_hex = is_hex(in_byte);
    assign b_nib = hex_nib(in_byte);

    always_comb
    begin
        res        = '0;
        state_next = state_reg;
        high_next  = high_reg;
        case (state_reg)
            PEND_ESC:
            begin
                if (in_last)
                begin
                    res.item[0] = '{last: 1'b0, data: ESC_CHAR};
                    res.item[1] = '{last: 1'b1, data: in_byte};
                    res.n       = 2'd2;
                    state_next  = PEND_NONE;
                end
                else if (b_hex && (b_nib >= MIN_HIGH_DIGIT))
                begin
                    high_next  = in_byte;
                    state_next = PEND_HIGH;
                end
                else
                begin
                    res.item[0] = '{last: 1'b0, data: ESC_CHAR};
                    if (in_byte == ESC_CHAR)
                    begin
                        res.n      = 2'd1;
                        state_next = PEND_ESC;
                    end
                    else
                    begin
                        res.item[1] = '{last: 1'b0, data: in_byte};
                        res.n       = 2'd2;
                        state_next  = PEND_NONE;
                    end
                end
            end
            PEND_HIGH:
            begin
                if (b_hex)
                begin
                    res.item[0] = '{last: in_last, data: {hex_nib(high_reg), b_nib}};
                    res.n       = 2'd1;
                    state_next  = PEND_NONE;
                end
                else
                begin
                    res.item[0] = '{last: 1'b0, data: ESC_CHAR};
                    res.item[1] = '{last: 1'b0, data: high_reg};
                    // a fresh '=' reopens the escape unless the text ends here
                    if ((in_byte == ESC_CHAR) && !in_last)
                    begin
                        res.n      = 2'd2;
                        state_next = PEND_ESC;
                    end
                    else
                    begin
                        res.item[2] = '{last: in_last, data: in_byte};
                        res.n       = 2'd3;
                        state_next  = PEND_NONE;
                    end
                end
            end
            default:
            begin
                if ((in_byte == ESC_CHAR) && !in_last)
                begin
                    state_next = PEND_ESC;
                end
                else
                begin
                    res.item[0] = '{last: in_last, data: in_byte};
                    res.n       = 2'd1;
                    state_next  = PEND_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PEND_NONE;
            high_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            high_reg  <= high_next;
        end
    end

endmodule

[sv/etd_checker.sv]
// Port-level checker for the escape text decoder and its bind statement.
module etd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared without an input transaction");

endmodule

bind escape_text_decoder etd_checker u_etd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[dv/escape_text_decoder_checker.sv]
// Checker for the escape text decoder: watches both streams, predicts decoded bytes, compares.
`timescale 1ns / 1ps

module escape_text_decoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         outstanding,
    output int         bytes_checked,
    output int         escapes_decoded,
    output int         texts_seen
);
    import etd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_byte_t;

    decoded_byte_t decoded_q[$];

    // 0: idle, 1: '=' held, 2: '=' and a high digit held
    logic [1:0] esc_depth   = 2'd0;
    logic [7:0] held_high   = 8'h00;
    int         mismatches  = 0;
    int         n_checked   = 0;
    int         n_escapes   = 0;
    int         n_texts     = 0;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= CHR_0 && c <= CHR_9)
        begin
            return int'(c - CHR_0);
        end
        if (c >= CHR_A && c <= CHR_F)
        begin
            return int'(c - CHR_A) + 10;
        end
        return -1;
    endfunction

    function automatic void push_decoded(input logic [7:0] data, input logic last);
        decoded_byte_t item;
        item.data = data;
        item.last = last;
        decoded_q.push_back(item);
    endfunction

    function automatic void take_plain(input logic [7:0] b, input logic last);
        if (b == ESC_CHAR && !last)
        begin
            esc_depth = 2'd1;
        end
        else
        begin
            push_decoded(b, last);
            esc_depth = 2'd0;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int         dv;
        logic [3:0] hi;
        dv = digit_value(b);
        case (esc_depth)
            2'd1:
            begin
                if (last)
                begin
                    push_decoded(ESC_CHAR, 1'b0);
                    push_decoded(b, 1'b1);
                    esc_depth = 2'd0;
                end
                else if (dv >= int'(MIN_HIGH_DIGIT))
                begin
                    held_high = b;
                    esc_depth = 2'd2;
                end
                else
                begin
                    push_decoded(ESC_CHAR, 1'b0);
                    take_plain(b, 1'b0);
                end
            end
            2'd2:
            begin
                if (dv >= 0)
                begin
                    hi = 4'(digit_value(held_high));
                    push_decoded({hi, 4'(dv)}, last);
                    esc_depth = 2'd0;
                    n_escapes++;
                end
                else
                begin
                    push_decoded(ESC_CHAR, 1'b0);
                    push_decoded(held_high, 1'b0);
                    take_plain(b, last);
                end
            end
            default:
            begin
                take_plain(b, last);
            end
        endcase
    endfunction

    function automatic void check_result(input logic [7:0] data, input logic last);
        decoded_byte_t want;
        if (decoded_q.size() == 0)
        begin
            $error("unexpected transaction: out_byte=%h out_last=%b", data, last);
            mismatches++;
            return;
        end
        want = decoded_q.pop_front();
        n_checked++;
        if (data !== want.data)
        begin
            $error("out_byte mismatch: expected %h, actual %h", want.data, data);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $error("out_last mismatch: expected %b, actual %b", want.last, last);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_depth = 2'd0;
            decoded_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tlast)
                begin
                    n_texts++;
                end
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata, m_tlast);
            end
        end
        outstanding     <= decoded_q.size();
        fail_count      <= mismatches;
        bytes_checked   <= n_checked;
        escapes_decoded <= n_escapes;
        texts_seen      <= n_texts;
    end

endmodule

[dv/escape_text_decoder_tb.sv]
// Testbench top for the escape text decoder: clock, reset, text stimulus, receiver, verdict.
`timescale 1ns / 1ps

module escape_text_decoder_tb;
    import etd_pkg::*;

    localparam int RANDOM_BYTES = 250;
    localparam int LONG_HOLD    = 120;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_tlast  = 1'b0;   // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // out_last

    int fail_count;
    int outstanding;
    int bytes_checked;
    int escapes_decoded;
    int texts_seen;

    int bytes_sent     = 0;
    int burst_left     = 0;
    int hold_requests  = 0;
    int holds_done     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    escape_text_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    escape_text_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .bytes_checked   (bytes_checked),
        .escapes_decoded (escapes_decoded),
        .texts_seen      (texts_seen)
    );

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
        begin
            return CHR_0 + 8'(v);
        end
        return CHR_A + 8'(v - 10);
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_A && c <= CHR_F);
    endfunction

    function automatic logic [7:0] non_digit_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (is_digit_char(c))
        begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Well-formed escapes with random content, mixed with broken ones and noise.
    task automatic send_random_text();
        logic [7:0] text_q[$];
        int         segs;
        int         kind;
        segs = $urandom_range(1, 8);
        repeat (segs)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            else if (kind <= 6)
            begin
                text_q.push_back(ESC_CHAR);
                text_q.push_back(digit_char($urandom_range(2, 15)));
                text_q.push_back(digit_char($urandom_range(0, 15)));
            end
            else if (kind == 7)
            begin
                text_q.push_back(ESC_CHAR);
                text_q.push_back(digit_char($urandom_range(0, 1)));
            end
            else if (kind == 8)
            begin
                text_q.push_back(ESC_CHAR);
                text_q.push_back(digit_char($urandom_range(2, 15)));
                text_q.push_back(non_digit_byte());
            end
            else
            begin
                text_q.push_back(ESC_CHAR);
            end
        end
        foreach (text_q[i])
        begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    // Receiver: phases of always-ready, random, mostly-ready and periodic stalls, plus long holds on request.
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            for (int c = 0; c < span; c++)
            begin
                if (hold_requests != holds_done)
                begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    holds_done++;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= (c % 3 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int texts_sent;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("=FF");
        send_text("=20");
        send_text("=1A");
        send_text("=4a");
        send_text("==41");
        send_text("=4=");
        send_text("=");
        send_text("=9");
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        texts_sent = 0;
        while (bytes_sent < 24 + RANDOM_BYTES)
        begin
            send_random_text();
            texts_sent++;
            if (texts_sent == 5)
            begin
                hold_requests <= hold_requests + 1;
            end
            // keep offering bytes while the receiver is held off
            if (texts_sent == 15 || (texts_sent != 5 && holds_done == hold_requests &&
                                     $urandom_range(0, 11) == 0))
            begin
                drain();
            end
        end
        drain();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d texts; checked %0d decoded bytes, %0d escapes decoded.",
                 bytes_sent, texts_seen, bytes_checked, escapes_decoded);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
